### src/cwpac_pkg.sv
// Package for the padded crop window block: shared constants, register
// indexes and the pipeline control struct. No dependencies.
package cwpac_pkg;

  // Default coordinate width
  localparam int unsigned COORD_BITS_DEF = 16;

  // Register widths
  localparam int unsigned MIN_SIZE_W = 16;
  localparam int unsigned ALIGN_W    = 13;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // Register indexes on the config channel
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE_MODE = 2'd2;

  // Reset values
  localparam logic [MIN_SIZE_W-1:0] MIN_SIZE_RST    = 16'd512;
  localparam logic [ALIGN_W-1:0]    ALIGN_RST       = 13'd8;
  localparam logic                  SQUARE_MODE_RST = 1'b1;

  // Dividend bits retired per remainder stage
  localparam int unsigned DIV_STEP = 3;

  // Pipeline control handed to every stage group
  typedef struct packed {
    logic en;     // all stages advance
    logic valid;  // word entering the group is valid
  } pipe_ctl_t;

endpackage

### src/cwpac_front.sv
// Front stages of the crop window pipe: input capture with square-mode
// padding, then padded minimum-size sides and the fallback window. Depends on cwpac_pkg.
module cwpac_front #(
  parameter int unsigned COORD_BITS = cwpac_pkg::COORD_BITS_DEF,
  parameter int unsigned GROW_W     = COORD_BITS + 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cwpac_pkg::pipe_ctl_t              ctl_i,
  input  logic [COORD_BITS-1:0]             box_x_i,
  input  logic [COORD_BITS-1:0]             box_y_i,
  input  logic [COORD_BITS-1:0]             box_w_i,
  input  logic [COORD_BITS-1:0]             box_h_i,
  input  logic [COORD_BITS-1:0]             doc_w_i,
  input  logic [COORD_BITS-1:0]             doc_h_i,
  input  logic signed [COORD_BITS-1:0]      pad_px_i,
  input  logic [cwpac_pkg::MIN_SIZE_W-1:0]  min_size_i,
  input  logic                              square_mode_i,
  output logic                              valid_o,
  output logic [GROW_W-1:0]                 grow_x_o,
  output logic [GROW_W-1:0]                 grow_y_o,
  output logic [COORD_BITS-1:0]             box_x_o,
  output logic [COORD_BITS-1:0]             box_y_o,
  output logic [COORD_BITS-1:0]             box_w_o,
  output logic [COORD_BITS-1:0]             box_h_o,
  output logic [COORD_BITS-1:0]             doc_w_o,
  output logic [COORD_BITS-1:0]             doc_h_o,
  output logic [COORD_BITS-1:0]             fb_x_o,
  output logic [COORD_BITS-1:0]             fb_y_o,
  output logic [COORD_BITS-1:0]             fb_w_o,
  output logic [COORD_BITS-1:0]             fb_h_o,
  output logic                              use_fb_o
);

  localparam int unsigned C = COORD_BITS;

  // Side plus twice the padding, raised to the minimum size
  function automatic logic [GROW_W-1:0] grow_fn(input logic [C-1:0] side,
                                                input logic [C-1:0] pad,
                                                input logic [cwpac_pkg::MIN_SIZE_W-1:0] msz);
    logic [C+1:0]      padded;
    logic [GROW_W+1:0] pe;
    logic [GROW_W+1:0] me;
    padded = {2'b00, side} + {pad[C-1], pad, 1'b0};
    pe = {{(GROW_W - C){padded[C+1]}}, padded};
    me = (GROW_W + 2)'(msz);
    if ($signed(pe) < $signed(me)) begin
      return me[GROW_W-1:0];
    end
    return pe[GROW_W-1:0];
  endfunction

  // ---------------- stage 0: capture and square-mode padding
  logic signed [C:0] pad_ext, pad_rnd, pad_half;
  logic        [C:0] d_x, d_y;
  logic signed [C:0] cand_x, cand_y, px_sel, py_sel;
  logic              wide, tall;

  always_comb begin
    pad_ext  = {pad_px_i[C-1], pad_px_i};
    pad_rnd  = pad_ext + $signed({{C{1'b0}}, pad_px_i[C-1]});
    pad_half = pad_rnd >>> 1;  // truncates toward zero
    d_x      = {1'b0, box_w_i} - {1'b0, box_h_i};
    d_y      = {1'b0, box_h_i} - {1'b0, box_w_i};
    cand_x   = pad_ext - $signed({1'b0, d_x[C:1]});
    cand_y   = pad_ext - $signed({1'b0, d_y[C:1]});
    wide     = box_w_i > box_h_i;
    tall     = box_h_i > box_w_i;
    px_sel   = pad_ext;
    py_sel   = pad_ext;
    if (square_mode_i && wide) begin
      px_sel = (cand_x > pad_half) ? cand_x : pad_half;
    end else if (square_mode_i && tall) begin
      py_sel = (cand_y > pad_half) ? cand_y : pad_half;
    end
  end

  logic         v0_q;
  logic [C-1:0] bx0_q, by0_q, bw0_q, bh0_q, dw0_q, dh0_q, px0_q, py0_q;
  logic         pass0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (ctl_i.en) begin
      v0_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      bx0_q   <= box_x_i;
      by0_q   <= box_y_i;
      bw0_q   <= box_w_i;
      bh0_q   <= box_h_i;
      dw0_q   <= doc_w_i;
      dh0_q   <= doc_h_i;
      px0_q   <= px_sel[C-1:0];
      py0_q   <= py_sel[C-1:0];
      pass0_q <= (box_w_i == '0) || (box_h_i == '0) || (doc_w_i == '0) || (doc_h_i == '0);
    end
  end

  // ---------------- stage 1: grown sides and fallback window
  logic [GROW_W-1:0] gx_d, gy_d;
  logic [C:0]        end_x, end_y;
  logic [C-1:0]      fbx_d, fby_d, fbw_d, fbh_d;

  always_comb begin
    gx_d  = grow_fn(bw0_q, px0_q, min_size_i);
    gy_d  = grow_fn(bh0_q, py0_q, min_size_i);
    end_x = {1'b0, bx0_q} + {1'b0, bw0_q};
    end_y = {1'b0, by0_q} + {1'b0, bh0_q};
    if (pass0_q) begin
      fbx_d = bx0_q;
      fby_d = by0_q;
      fbw_d = bw0_q;
      fbh_d = bh0_q;
    end else if ((bx0_q >= dw0_q) || (by0_q >= dh0_q)) begin
      fbx_d = '0;
      fby_d = '0;
      fbw_d = '0;
      fbh_d = '0;
    end else begin
      // box intersected with document
      fbx_d = bx0_q;
      fby_d = by0_q;
      fbw_d = (end_x < {1'b0, dw0_q}) ? bw0_q : (dw0_q - bx0_q);
      fbh_d = (end_y < {1'b0, dh0_q}) ? bh0_q : (dh0_q - by0_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (ctl_i.en) begin
      valid_o <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      grow_x_o <= gx_d;
      grow_y_o <= gy_d;
      box_x_o  <= bx0_q;
      box_y_o  <= by0_q;
      box_w_o  <= bw0_q;
      box_h_o  <= bh0_q;
      doc_w_o  <= dw0_q;
      doc_h_o  <= dh0_q;
      fb_x_o   <= fbx_d;
      fb_y_o   <= fby_d;
      fb_w_o   <= fbw_d;
      fb_h_o   <= fbh_d;
      use_fb_o <= pass0_q || (gx_d == '0) || (gy_d == '0);
    end
  end

endmodule

### src/cwpac_mod_pipe.sv
// Pipelined restoring remainder unit: two dividends by one divisor, STEP
// dividend bits per stage, with a payload carried alongside. Uses cwpac_pkg.
module cwpac_mod_pipe #(
  parameter int unsigned DW   = 17,
  parameter int unsigned MW   = cwpac_pkg::ALIGN_W,
  parameter int unsigned PW   = 1,
  parameter int unsigned STEP = cwpac_pkg::DIV_STEP
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cwpac_pkg::pipe_ctl_t ctl_i,
  input  logic [MW-1:0]        m_i,      // divisor, never zero
  input  logic [DW-1:0]        a_i,
  input  logic [DW-1:0]        b_i,
  input  logic [PW-1:0]        pay_i,
  output logic                 valid_o,
  output logic [DW-1:0]        a_o,
  output logic [DW-1:0]        b_o,
  output logic [MW-1:0]        rem_a_o,
  output logic [MW-1:0]        rem_b_o,
  output logic [PW-1:0]        pay_o
);

  localparam int unsigned NS = (DW + STEP - 1) / STEP;
  localparam int unsigned EW = NS * STEP;

  // STEP restoring steps: shift in a bit, subtract once if it fits
  function automatic logic [MW-1:0] rem_step(input logic [MW-1:0] r_in,
                                             input logic [STEP-1:0] bits,
                                             input logic [MW-1:0] m);
    logic [MW:0]   t;
    logic [MW-1:0] r;
    r = r_in;
    for (int k = STEP - 1; k >= 0; k--) begin
      t = {r, bits[k]};
      if (t >= {1'b0, m}) begin
        t = t - {1'b0, m};
      end
      r = t[MW-1:0];
    end
    return r;
  endfunction

  logic [NS-1:0] valid_q;
  logic [DW-1:0] a_q  [NS];
  logic [DW-1:0] b_q  [NS];
  logic [MW-1:0] ra_q [NS];
  logic [MW-1:0] rb_q [NS];
  logic [PW-1:0] pay_q[NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic          v_src;
    logic [DW-1:0] a_src, b_src;
    logic [MW-1:0] ra_src, rb_src;
    logic [PW-1:0] p_src;
    logic [EW-1:0] a_ext, b_ext;

    if (s == 0) begin : g_first
      assign v_src  = ctl_i.valid;
      assign a_src  = a_i;
      assign b_src  = b_i;
      assign ra_src = '0;
      assign rb_src = '0;
      assign p_src  = pay_i;
    end else begin : g_next
      assign v_src  = valid_q[s-1];
      assign a_src  = a_q[s-1];
      assign b_src  = b_q[s-1];
      assign ra_src = ra_q[s-1];
      assign rb_src = rb_q[s-1];
      assign p_src  = pay_q[s-1];
    end

    assign a_ext = EW'(a_src);
    assign b_ext = EW'(b_src);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (ctl_i.en) begin
        valid_q[s] <= v_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        a_q[s]   <= a_src;
        b_q[s]   <= b_src;
        ra_q[s]  <= rem_step(ra_src, a_ext[(NS-s)*STEP-1 -: STEP], m_i);
        rb_q[s]  <= rem_step(rb_src, b_ext[(NS-s)*STEP-1 -: STEP], m_i);
        pay_q[s] <= p_src;
      end
    end
  end

  assign valid_o = valid_q[NS-1];
  assign a_o     = a_q[NS-1];
  assign b_o     = b_q[NS-1];
  assign rem_a_o = ra_q[NS-1];
  assign rem_b_o = rb_q[NS-1];
  assign pay_o   = pay_q[NS-1];

`ifndef SYNTH
  // a finished remainder is always below the divisor
  a_rem_below_m: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((rem_a_o < m_i) && (rem_b_o < m_i)))
    else $error("remainder not below divisor");
`endif

endmodule

### src/cwpac_back.sv
// Back stages of the crop window pipe: aligned size, recentred start,
// clamping into the document or the fallback window, and the output register. Uses cwpac_pkg.
module cwpac_back #(
  parameter int unsigned COORD_BITS = cwpac_pkg::COORD_BITS_DEF,
  parameter int unsigned GROW_W     = COORD_BITS + 1,
  parameter int unsigned SIZE_W     = GROW_W + 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cwpac_pkg::pipe_ctl_t           ctl_i,
  input  logic [cwpac_pkg::ALIGN_W-1:0]  m_i,
  input  logic [GROW_W-1:0]              grow_x_i,
  input  logic [GROW_W-1:0]              grow_y_i,
  input  logic [cwpac_pkg::ALIGN_W-1:0]  rem_x_i,
  input  logic [cwpac_pkg::ALIGN_W-1:0]  rem_y_i,
  input  logic [COORD_BITS-1:0]          box_x_i,
  input  logic [COORD_BITS-1:0]          box_y_i,
  input  logic [COORD_BITS-1:0]          box_w_i,
  input  logic [COORD_BITS-1:0]          box_h_i,
  input  logic [COORD_BITS-1:0]          doc_w_i,
  input  logic [COORD_BITS-1:0]          doc_h_i,
  input  logic [COORD_BITS-1:0]          fb_x_i,
  input  logic [COORD_BITS-1:0]          fb_y_i,
  input  logic [COORD_BITS-1:0]          fb_w_i,
  input  logic [COORD_BITS-1:0]          fb_h_i,
  input  logic                           use_fb_i,
  output logic                           valid_o,
  output logic [COORD_BITS-1:0]          win_x_o,
  output logic [COORD_BITS-1:0]          win_y_o,
  output logic [COORD_BITS-1:0]          win_w_o,
  output logic [COORD_BITS-1:0]          win_h_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned ST = SIZE_W + 2;  // signed start width

  // ---------------- stage A: round up to the multiple
  logic [SIZE_W-1:0] sx_d, sy_d;
  assign sx_d = SIZE_W'(grow_x_i) + ((rem_x_i == '0) ? '0 : SIZE_W'(m_i - rem_x_i));
  assign sy_d = SIZE_W'(grow_y_i) + ((rem_y_i == '0) ? '0 : SIZE_W'(m_i - rem_y_i));

  logic              v1_q;
  logic [SIZE_W-1:0] sx1_q, sy1_q;
  logic [C-1:0]      bx1_q, by1_q, bw1_q, bh1_q, dw1_q, dh1_q;
  logic [C-1:0]      fbx1_q, fby1_q, fbw1_q, fbh1_q;
  logic              fb1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ctl_i.en) begin
      v1_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      sx1_q  <= sx_d;
      sy1_q  <= sy_d;
      bx1_q  <= box_x_i;
      by1_q  <= box_y_i;
      bw1_q  <= box_w_i;
      bh1_q  <= box_h_i;
      dw1_q  <= doc_w_i;
      dh1_q  <= doc_h_i;
      fbx1_q <= fb_x_i;
      fby1_q <= fb_y_i;
      fbw1_q <= fb_w_i;
      fbh1_q <= fb_h_i;
      fb1_q  <= use_fb_i;
    end
  end

  // ---------------- stage B: recentre, start = p - (size - s) / 2
  function automatic logic [ST-1:0] start_fn(input logic [C-1:0] p,
                                             input logic [C-1:0] s,
                                             input logic [SIZE_W-1:0] size);
    logic signed [SIZE_W:0] diff;
    logic signed [SIZE_W:0] rnd;
    logic signed [ST-1:0]   st;
    diff = $signed({1'b0, size}) - $signed((SIZE_W + 1)'(s));
    rnd  = diff + $signed({{SIZE_W{1'b0}}, diff[SIZE_W]});
    st   = $signed(ST'(p)) - (ST'(rnd >>> 1));
    return st;
  endfunction

  logic [ST-1:0] stx_d, sty_d;
  assign stx_d = start_fn(bx1_q, bw1_q, sx1_q);
  assign sty_d = start_fn(by1_q, bh1_q, sy1_q);

  logic              v2_q;
  logic [ST-1:0]     stx2_q, sty2_q;
  logic [SIZE_W-1:0] sx2_q, sy2_q;
  logic              gex2_q, gey2_q;
  logic [C-1:0]      dw2_q, dh2_q;
  logic [C-1:0]      fbx2_q, fby2_q, fbw2_q, fbh2_q;
  logic              fb2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ctl_i.en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      stx2_q <= stx_d;
      sty2_q <= sty_d;
      sx2_q  <= sx1_q;
      sy2_q  <= sy1_q;
      gex2_q <= sx1_q >= SIZE_W'(dw1_q);
      gey2_q <= sy1_q >= SIZE_W'(dh1_q);
      dw2_q  <= dw1_q;
      dh2_q  <= dh1_q;
      fbx2_q <= fbx1_q;
      fby2_q <= fby1_q;
      fbw2_q <= fbw1_q;
      fbh2_q <= fbh1_q;
      fb2_q  <= fb1_q;
    end
  end

  // ---------------- stage C: clamp into the document
  // start clipped at zero, then pulled back if the end passes the edge
  function automatic logic [C-1:0] clamp_fn(input logic [ST-1:0] st,
                                            input logic [SIZE_W-1:0] size,
                                            input logic [C-1:0] lim);
    logic [ST-2:0] off;
    logic [ST-1:0] endp;
    off  = st[ST-1] ? '0 : st[ST-2:0];
    endp = {1'b0, off} + ST'(size);
    if (endp > ST'(lim)) begin
      return lim - size[C-1:0];
    end
    return off[C-1:0];
  endfunction

  logic [C-1:0] wx_d, wy_d, ww_d, wh_d;

  always_comb begin
    if (fb2_q) begin
      wx_d = fbx2_q;
      wy_d = fby2_q;
      ww_d = fbw2_q;
      wh_d = fbh2_q;
    end else begin
      wx_d = gex2_q ? '0 : clamp_fn(stx2_q, sx2_q, dw2_q);
      ww_d = gex2_q ? dw2_q : sx2_q[C-1:0];
      wy_d = gey2_q ? '0 : clamp_fn(sty2_q, sy2_q, dh2_q);
      wh_d = gey2_q ? dh2_q : sy2_q[C-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (ctl_i.en) begin
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      win_x_o <= wx_d;
      win_y_o <= wy_d;
      win_w_o <= ww_d;
      win_h_o <= wh_d;
    end
  end

`ifndef SYNTH
  // a window that is computed (not a fallback) never has a zero side
  a_size_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !fb1_q) |-> ((sx1_q != '0) && (sy1_q != '0)))
    else $error("computed window side is zero");

  // a clamped window lies inside the document
  a_inside_doc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !fb2_q) |-> ((({1'b0, wx_d} + {1'b0, ww_d}) <= {1'b0, dw2_q}) &&
                          (({1'b0, wy_d} + {1'b0, wh_d}) <= {1'b0, dh2_q})))
    else $error("clamped window leaves the document");
`endif

endmodule

### src/crop_window_pad_align_clamp_top.sv
// The remainder pipe for the alignment multiple retires three dividend
// bits per stage of its GW = max(COORD_BITS+1, 16) bit dividends.
// Throughput: one word per cycle; the whole pipe holds only while the
// output register is full and not taken. Reset clears all valid bits and
// loads min_size 512, align_multiple 8, square_mode 1.
module crop_window_pad_align_clamp_top #(
  parameter int unsigned COORD_BITS = cwpac_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // box_x, box_y, box_w, box_h, doc_w, doc_h, pad_px (lowest first)
  input  logic [((7*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // win_x, win_y, win_w, win_h (lowest first)
  output logic [((4*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cwpac_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cwpac_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned OUT_W  = ((4*C + 7) / 8) * 8;
  localparam int unsigned GROW_W = (C + 1 > cwpac_pkg::MIN_SIZE_W) ? C + 1
                                                                   : cwpac_pkg::MIN_SIZE_W;
  localparam int unsigned SIZE_W = GROW_W + 1;
  localparam int unsigned PAY_W  = 10*C + 1;
  localparam int unsigned AW     = cwpac_pkg::ALIGN_W;

  // ---------------- config registers
  logic [cwpac_pkg::MIN_SIZE_W-1:0] min_size_q;
  logic [AW-1:0]                    align_q;
  logic                             square_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q <= cwpac_pkg::MIN_SIZE_RST;
      align_q    <= cwpac_pkg::ALIGN_RST;
      square_q   <= cwpac_pkg::SQUARE_MODE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cwpac_pkg::REG_MIN_SIZE:    min_size_q <= cfg_data_i[cwpac_pkg::MIN_SIZE_W-1:0];
        cwpac_pkg::REG_ALIGN:       align_q    <= cfg_data_i[AW-1:0];
        cwpac_pkg::REG_SQUARE_MODE: square_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // a zero multiple acts as one
  logic [AW-1:0] mult;
  assign mult = (align_q == '0) ? AW'(1) : align_q;

  // ---------------- pipeline control
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  cwpac_pkg::pipe_ctl_t front_ctl, div_ctl, back_ctl;
  logic front_valid, div_valid;

  assign front_ctl = '{en: adv, valid: s_axis_tvalid};
  assign div_ctl   = '{en: adv, valid: front_valid};
  assign back_ctl  = '{en: adv, valid: div_valid};

  // ---------------- front stages
  logic [GROW_W-1:0] grow_x, grow_y;
  logic [C-1:0]      f_bx, f_by, f_bw, f_bh, f_dw, f_dh;
  logic [C-1:0]      f_fbx, f_fby, f_fbw, f_fbh;
  logic              f_fb;

  cwpac_front #(
    .COORD_BITS (C),
    .GROW_W     (GROW_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (front_ctl),
    .box_x_i       (s_axis_tdata[0*C +: C]),
    .box_y_i       (s_axis_tdata[1*C +: C]),
    .box_w_i       (s_axis_tdata[2*C +: C]),
    .box_h_i       (s_axis_tdata[3*C +: C]),
    .doc_w_i       (s_axis_tdata[4*C +: C]),
    .doc_h_i       (s_axis_tdata[5*C +: C]),
    .pad_px_i      (s_axis_tdata[6*C +: C]),
    .min_size_i    (min_size_q),
    .square_mode_i (square_q),
    .valid_o       (front_valid),
    .grow_x_o      (grow_x),
    .grow_y_o      (grow_y),
    .box_x_o       (f_bx),
    .box_y_o       (f_by),
    .box_w_o       (f_bw),
    .box_h_o       (f_bh),
    .doc_w_o       (f_dw),
    .doc_h_o       (f_dh),
    .fb_x_o        (f_fbx),
    .fb_y_o        (f_fby),
    .fb_w_o        (f_fbw),
    .fb_h_o        (f_fbh),
    .use_fb_o      (f_fb)
  );

  // ---------------- remainder pipe, side data rides along
  logic [PAY_W-1:0]  pay_in, pay_out;
  logic [GROW_W-1:0] d_gx, d_gy;
  logic [AW-1:0]     rem_x, rem_y;

  assign pay_in = {f_fb, f_fbh, f_fbw, f_fby, f_fbx, f_dh, f_dw, f_bh, f_bw, f_by, f_bx};

  cwpac_mod_pipe #(
    .DW   (GROW_W),
    .MW   (AW),
    .PW   (PAY_W),
    .STEP (cwpac_pkg::DIV_STEP)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (div_ctl),
    .m_i     (mult),
    .a_i     (grow_x),
    .b_i     (grow_y),
    .pay_i   (pay_in),
    .valid_o (div_valid),
    .a_o     (d_gx),
    .b_o     (d_gy),
    .rem_a_o (rem_x),
    .rem_b_o (rem_y),
    .pay_o   (pay_out)
  );

  // ---------------- back stages and output register
  logic [C-1:0] win_x, win_y, win_w, win_h;

  cwpac_back #(
    .COORD_BITS (C),
    .GROW_W     (GROW_W),
    .SIZE_W     (SIZE_W)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (back_ctl),
    .m_i      (mult),
    .grow_x_i (d_gx),
    .grow_y_i (d_gy),
    .rem_x_i  (rem_x),
    .rem_y_i  (rem_y),
    .box_x_i  (pay_out[0*C +: C]),
    .box_y_i  (pay_out[1*C +: C]),
    .box_w_i  (pay_out[2*C +: C]),
    .box_h_i  (pay_out[3*C +: C]),
    .doc_w_i  (pay_out[4*C +: C]),
    .doc_h_i  (pay_out[5*C +: C]),
    .fb_x_i   (pay_out[6*C +: C]),
    .fb_y_i   (pay_out[7*C +: C]),
    .fb_w_i   (pay_out[8*C +: C]),
    .fb_h_i   (pay_out[9*C +: C]),
    .use_fb_i (pay_out[10*C]),
    .valid_o  (m_axis_tvalid),
    .win_x_o  (win_x),
    .win_y_o  (win_y),
    .win_w_o  (win_w),
    .win_h_o  (win_h)
  );

  assign m_axis_tdata = OUT_W'({win_h, win_w, win_y, win_x});

`ifndef SYNTH
  // the pipe only holds back input while a result waits at the output
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output register");
`endif

endmodule

### tb/crop_window_pad_align_clamp_top_test.sv
// Self-checking testbench for crop_window_pad_align_clamp_top: directed and
// random window requests, a bit-exact window predictor and stream checks.
// Depends on cwpac_pkg and the RTL top level only.
module crop_window_pad_align_clamp_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_BITS       = cwpac_pkg::COORD_BITS_DEF;
  localparam int unsigned CFG_IDX_W        = cwpac_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W       = cwpac_pkg::CFG_DATA_W;
  localparam int unsigned MIN_SIZE_W       = cwpac_pkg::MIN_SIZE_W;
  localparam int unsigned ALIGN_W          = cwpac_pkg::ALIGN_W;
  localparam int unsigned REQ_W            = ((7*COORD_BITS+7)/8)*8;
  localparam int unsigned WIN_W            = ((4*COORD_BITS+7)/8)*8;
  // depth of the pipe at 16-bit coordinates
  localparam int unsigned PIPE_LATENCY     = 11;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned IDLE_LIMIT       = 4000;
  localparam int unsigned RANDOM_PER_PHASE = 100;
  localparam int unsigned MAX_PRINTED      = 40;
  // index past the last register, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // first member in the highest bits, so box_x lands at bit 0
  typedef struct packed {
    logic [COORD_BITS-1:0] pad_px;
    logic [COORD_BITS-1:0] doc_h;
    logic [COORD_BITS-1:0] doc_w;
    logic [COORD_BITS-1:0] box_h;
    logic [COORD_BITS-1:0] box_w;
    logic [COORD_BITS-1:0] box_y;
    logic [COORD_BITS-1:0] box_x;
  } crop_req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] win_h;
    logic [COORD_BITS-1:0] win_w;
    logic [COORD_BITS-1:0] win_y;
    logic [COORD_BITS-1:0] win_x;
  } crop_win_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // box_x, box_y, box_w, box_h, doc_w, doc_h, pad_px (lowest first)
  logic [REQ_W-1:0]      s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // win_x, win_y, win_w, win_h (lowest first)
  logic [WIN_W-1:0]      m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // shadow copy of the register file
  logic [MIN_SIZE_W-1:0] cfg_min_size;
  logic [ALIGN_W-1:0]    cfg_align;
  logic                  cfg_square;

  crop_win_t expected_windows[$];
  int unsigned errors;

  // sender burst control
  bit          tx_idle_en;
  bit          offering;
  int unsigned burst_left;

  // receiver stall control
  bit          rx_steady;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned rx_run_left;
  bit          rx_run_ready;

  crop_window_pad_align_clamp_top #(
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Window predictor
  // ---------------------------------------------------------------------

  // pad, raise to min size, round up to the multiple, recenter
  function automatic void grow_axis(input longint pos, input longint side,
                                    input longint pad, output longint wpos,
                                    output longint wside);
    longint m;
    longint grown;
    longint span;
    m = longint'(cfg_align);
    if (m == 0) m = 1;
    grown = side + 2 * pad;
    if (grown < longint'(cfg_min_size)) grown = longint'(cfg_min_size);
    span  = ((grown + m - 1) / m) * m;
    wpos  = pos - (span - side) / 2;
    wside = span;
  endfunction

  // fit into [0, limit); oversize spans the whole axis
  function automatic void clamp_axis(inout longint pos, inout longint side,
                                     input longint limit);
    longint lo;
    longint over;
    if (side >= limit) begin
      pos  = 0;
      side = limit;
    end else begin
      lo   = (pos > 0) ? pos : 0;
      over = lo + side - limit;
      if (over < 0) over = 0;
      pos  = lo - over;
    end
  endfunction

  function automatic crop_win_t predict_window(crop_req_t r);
    longint bx, by, bw, bh, dw, dh, px, py;
    longint wx, wy, ww, wh;
    crop_win_t w;
    bx = longint'(r.box_x);
    by = longint'(r.box_y);
    bw = longint'(r.box_w);
    bh = longint'(r.box_h);
    dw = longint'(r.doc_w);
    dh = longint'(r.doc_h);
    px = longint'($signed(r.pad_px));
    py = px;
    // empty box or document: box passes through
    if (bw == 0 || bh == 0 || dw == 0 || dh == 0) begin
      w.win_x = r.box_x;
      w.win_y = r.box_y;
      w.win_w = r.box_w;
      w.win_h = r.box_h;
      return w;
    end
    // square mode trims the pad on the longer side
    if (cfg_square && bw > bh)
      px = (px / 2 > px - (bw - bh) / 2) ? px / 2 : px - (bw - bh) / 2;
    else if (cfg_square && bh > bw)
      py = (py / 2 > py - (bh - bw) / 2) ? py / 2 : py - (bh - bw) / 2;
    grow_axis(bx, bw, px, wx, ww);
    grow_axis(by, bh, py, wy, wh);
    clamp_axis(wx, ww, dw);
    clamp_axis(wy, wh, dh);
    // empty window: fall back to box clipped to the document
    if (ww <= 0 || wh <= 0) begin
      if (bx >= dw || by >= dh) begin
        wx = 0;
        wy = 0;
        ww = 0;
        wh = 0;
      end else begin
        wx = bx;
        wy = by;
        ww = ((bx + bw < dw) ? bx + bw : dw) - bx;
        wh = ((by + bh < dh) ? by + bh : dh) - by;
      end
    end
    w.win_x = wx[COORD_BITS-1:0];
    w.win_y = wy[COORD_BITS-1:0];
    w.win_w = ww[COORD_BITS-1:0];
    w.win_h = wh[COORD_BITS-1:0];
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic crop_req_t mk_req(input int unsigned bx, input int unsigned by,
                                       input int unsigned bw, input int unsigned bh,
                                       input int unsigned dw, input int unsigned dh,
                                       input logic [COORD_BITS-1:0] pad);
    crop_req_t r;
    r.box_x  = bx[COORD_BITS-1:0];
    r.box_y  = by[COORD_BITS-1:0];
    r.box_w  = bw[COORD_BITS-1:0];
    r.box_h  = bh[COORD_BITS-1:0];
    r.doc_w  = dw[COORD_BITS-1:0];
    r.doc_h  = dh[COORD_BITS-1:0];
    r.pad_px = pad;
    return r;
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_side();
    case ($urandom_range(0, 4))
      0:       return COORD_BITS'($urandom_range(1, 32));
      1:       return COORD_BITS'($urandom_range(1, 600));
      2:       return COORD_BITS'($urandom_range(1, 4000));
      3:       return COORD_BITS'($urandom_range(1, 65535));
      default: return COORD_BITS'($urandom_range(65000, 65535));
    endcase
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_pad();
    case ($urandom_range(0, 5))
      0:       return COORD_BITS'($urandom_range(0, 64));
      1:       return COORD_BITS'(int'($urandom_range(0, 128)) - 64);
      2:       return COORD_BITS'(-int'($urandom_range(0, 2000)));
      3:       return COORD_BITS'($urandom_range(0, 300));
      4:       return COORD_BITS'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
    endcase
  endfunction

  // mostly boxes inside the document, some noise and degenerate ones
  function automatic crop_req_t make_random_req();
    crop_req_t r;
    int unsigned kind;
    kind     = $urandom_range(0, 99);
    r.doc_w  = rand_side();
    r.doc_h  = rand_side();
    r.box_x  = COORD_BITS'($urandom_range(0, r.doc_w - 1));
    r.box_y  = COORD_BITS'($urandom_range(0, r.doc_h - 1));
    r.box_w  = COORD_BITS'($urandom_range(1, r.doc_w - r.box_x));
    r.box_h  = COORD_BITS'($urandom_range(1, r.doc_h - r.box_y));
    r.pad_px = rand_pad();
    if (kind < 10) begin
      r.box_x  = COORD_BITS'($urandom);
      r.box_y  = COORD_BITS'($urandom);
      r.box_w  = COORD_BITS'($urandom);
      r.box_h  = COORD_BITS'($urandom);
      r.doc_w  = COORD_BITS'($urandom);
      r.doc_h  = COORD_BITS'($urandom);
      r.pad_px = COORD_BITS'($urandom);
    end else if (kind < 18) begin
      case ($urandom_range(0, 3))
        0:       r.box_w = '0;
        1:       r.box_h = '0;
        2:       r.doc_w = '0;
        default: r.doc_h = '0;
      endcase
    end else if (kind < 28) begin
      // box reaching past or lying outside the document
      r.box_x = rand_side();
      r.box_y = rand_side();
      r.box_w = rand_side();
      r.box_h = rand_side();
    end
    return r;
  endfunction

  // offer one request, predict it on acceptance, then maybe idle
  task automatic send_window_req(input crop_req_t r);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r;
    offering = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_windows.push_back(predict_window(r));
    gap = 0;
    if (tx_idle_en) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap        = $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every window has come back
  task automatic drain_results();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
    while (expected_windows.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY) @(posedge clk_i);
  endtask

  // register write; valid stays up across back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      cwpac_pkg::REG_MIN_SIZE:    cfg_min_size = data[MIN_SIZE_W-1:0];
      cwpac_pkg::REG_ALIGN:       cfg_align    = data[ALIGN_W-1:0];
      cwpac_pkg::REG_SQUARE_MODE: cfg_square   = data[0];
      default:                    ;
    endcase
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic report_error(input string what, input longint got,
                              input longint want);
    if (errors < MAX_PRINTED)
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // reset register values: pass-through, extremes, square trim, clamping
  task automatic test_reset_values();
    tx_idle_en = 1'b1;
    send_window_req(mk_req(0, 0, 0, 0, 0, 0, 16'h0000));
    send_window_req(mk_req(100, 200, 0, 50, 1000, 1000, 16'd10));
    send_window_req(mk_req(100, 200, 50, 0, 1000, 1000, 16'd10));
    send_window_req(mk_req(65535, 65535, 65535, 65535, 0, 500, 16'h7FFF));
    send_window_req(mk_req(5, 6, 7, 8, 500, 0, 16'h8000));
    send_window_req(mk_req(65535, 65535, 65535, 65535, 65535, 65535, 16'h7FFF));
    send_window_req(mk_req(65535, 65535, 65535, 65535, 65535, 65535, 16'h8000));
    send_window_req(mk_req(1000, 1000, 400, 100, 4000, 4000, 16'd50));
    send_window_req(mk_req(1000, 1000, 100, 400, 4000, 4000, -16'sd50));
    send_window_req(mk_req(3900, 3950, 100, 40, 4000, 4000, 16'd20));
    send_window_req(mk_req(10, 10, 100, 100, 300, 200, 16'd0));
    send_window_req(mk_req(33, 77, 601, 601, 2000, 1500, 16'd3));
  endtask

  // min size 0 with negative pads collapses the window
  task automatic test_empty_window();
    drain_results();
    write_reg(cwpac_pkg::REG_MIN_SIZE, 16'd0, 1'b0);
    write_reg(cwpac_pkg::REG_ALIGN, 16'd1, 1'b0);
    write_reg(cwpac_pkg::REG_SQUARE_MODE, 16'd0, 1'b1);
    send_window_req(mk_req(10, 10, 20, 20, 100, 100, 16'h8000));
    send_window_req(mk_req(90, 95, 50, 50, 100, 100, -16'sd30));
    send_window_req(mk_req(150, 10, 20, 20, 100, 100, -16'sd30));
    send_window_req(mk_req(10, 150, 20, 20, 100, 100, -16'sd30));
    // zero multiple behaves as one
    drain_results();
    write_reg(cwpac_pkg::REG_ALIGN, 16'd0, 1'b1);
    send_window_req(mk_req(10, 10, 21, 21, 100, 100, -16'sd10));
    send_window_req(mk_req(10, 10, 21, 21, 100, 100, -16'sd11));
  endtask

  // written values cut to register width; unused index ignored
  task automatic test_register_cuts();
    drain_results();
    write_reg(cwpac_pkg::REG_ALIGN, 16'hFFFF, 1'b0);
    write_reg(cwpac_pkg::REG_MIN_SIZE, 16'hFFFF, 1'b0);
    write_reg(cwpac_pkg::REG_SQUARE_MODE, 16'h0003, 1'b0);
    write_reg(REG_UNUSED, 16'h1234, 1'b1);
    send_window_req(mk_req(100, 100, 300, 50, 65535, 65535, 16'd10));
    send_window_req(mk_req(0, 0, 1, 1, 65535, 9000, 16'd0));
  endtask

  task automatic test_random_settings();
    logic [CFG_DATA_W-1:0] min_v;
    logic [CFG_DATA_W-1:0] align_v;
    logic [CFG_DATA_W-1:0] sq_v;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          min_v   = CFG_DATA_W'(cwpac_pkg::MIN_SIZE_RST);
          align_v = CFG_DATA_W'(cwpac_pkg::ALIGN_RST);
          sq_v    = CFG_DATA_W'(cwpac_pkg::SQUARE_MODE_RST);
        end
        1: begin min_v = 16'd0;     align_v = 16'd1;    sq_v = 16'd0; end
        2: begin min_v = 16'hFFFF;  align_v = 16'd4096; sq_v = 16'd1; end
        3: begin min_v = 16'd37;    align_v = 16'd3;    sq_v = 16'd1; end
        4: begin min_v = 16'd255;   align_v = 16'hE000; sq_v = 16'd0; end
        default: begin
          min_v   = CFG_DATA_W'($urandom_range(0, 65535));
          align_v = 16'hFFFF;
          sq_v    = 16'hFFFE;
        end
      endcase
      drain_results();
      write_reg(cwpac_pkg::REG_MIN_SIZE, min_v, 1'b0);
      write_reg(cwpac_pkg::REG_ALIGN, align_v, 1'b0);
      write_reg(cwpac_pkg::REG_SQUARE_MODE, sq_v, 1'b1);
      // phase 2 runs with no idling on either side
      tx_idle_en = (phase != 2);
      rx_steady  = (phase == 2);
      repeat (RANDOM_PER_PHASE) send_window_req(make_random_req());
    end
    rx_steady = 1'b0;
  endtask

  // receiver holds off long enough for the pipe to fill and stall input
  task automatic test_output_hold();
    drain_results();
    write_reg(cwpac_pkg::REG_MIN_SIZE, 16'd64, 1'b0);
    write_reg(cwpac_pkg::REG_ALIGN, 16'd16, 1'b0);
    write_reg(cwpac_pkg::REG_SQUARE_MODE, 16'd1, 1'b1);
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    repeat (40) send_window_req(make_random_req());
    tx_idle_en = 1'b1;
  endtask

  // sender pauses until every window is back, then resumes
  task automatic test_paused_sender();
    repeat (15) send_window_req(make_random_req());
    drain_results();
    repeat (15) send_window_req(make_random_req());
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random ready/stall runs, steady mode, long hold
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (rx_run_left == 0) begin
        rx_run_left  = $urandom_range(1, 12);
        rx_run_ready = ($urandom_range(0, 2) != 0);
      end
      rx_run_left--;
      m_axis_tready <= rx_run_ready;
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: compare each accepted word with the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : check_windows
    crop_win_t got;
    crop_win_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_windows.size() == 0) begin
        report_error("window with nothing pending, win_x", got.win_x, 0);
      end else begin
        want = expected_windows.pop_front();
        if (got.win_x !== want.win_x) report_error("win_x", got.win_x, want.win_x);
        if (got.win_y !== want.win_y) report_error("win_y", got.win_y, want.win_y);
        if (got.win_w !== want.win_w) report_error("win_w", got.win_w, want.win_w);
        if (got.win_h !== want.win_h) report_error("win_h", got.win_h, want.win_h);
      end
    end
  end

  // Watchdog: too many cycles without any word moving
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("[%0t] watchdog: no word moved for %0d cycles", $time, IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Main sequence
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = cwpac_pkg::REG_MIN_SIZE;
    cfg_data_i    = '0;
    cfg_min_size  = cwpac_pkg::MIN_SIZE_RST;
    cfg_align     = cwpac_pkg::ALIGN_RST;
    cfg_square    = cwpac_pkg::SQUARE_MODE_RST;
    errors        = 0;
    tx_idle_en    = 1'b1;
    offering      = 1'b0;
    burst_left    = 0;
    rx_steady     = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    rx_run_left   = 0;
    rx_run_ready  = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_empty_window();
    test_register_cuts();
    test_random_settings();
    test_output_hold();
    test_paused_sender();
    drain_results();

    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
